FILE: rtl/core/dxtd_pkg.sv
// Shared types, format codes and fixed-point helpers for the DXT block decoder.
// No dependencies; used by dxtd_palette, the decoder unit, dxtd_checker and the bench.
package dxtd_pkg;

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    localparam logic [1:0] LAST_ROW = 2'd3;

    // Color entries hold red in 7:0, green in 15:8, blue in 23:16.
    typedef struct packed {
        logic [3:0][23:0] color;
        logic             four;    // c0 > c1: four opaque colors, else entry 3 is clear
        logic [7:0][7:0]  alpha;
    } palette_t;

    // floor(v*255/31) = 8v + floor(7v/31); 265/8192 is exact enough for 7v <= 217
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0]  n;
        logic [16:0] p;
        n = {v, 3'b000} - {3'b000, v};
        p = {9'd0, n} * 17'd265;
        return {v, 3'b000} + {5'd0, p[15:13]};
    endfunction

    // floor(v*255/63) = 4v + floor(v/21)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] q;
        if (v >= 6'd63)
            q = 2'd3;
        else if (v >= 6'd42)
            q = 2'd2;
        else if (v >= 6'd21)
            q = 2'd1;
        else
            q = 2'd0;
        return {v, 2'b00} + {6'd0, q};
    endfunction

    // floor(n/3) for n <= 765
    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [19:0] p;
        p = {10'd0, n} * 20'd683;
        return p[18:11];
    endfunction

    // floor(n/5) for n <= 1275
    function automatic logic [7:0] div5(input logic [10:0] n);
        logic [23:0] p;
        p = {13'd0, n} * 24'd6554;
        return p[22:15];
    endfunction

    // floor(n/7) for n <= 1785
    function automatic logic [7:0] div7(input logic [10:0] n);
        logic [23:0] p;
        p = {13'd0, n} * 24'd4682;
        return p[22:15];
    endfunction

endpackage

FILE: rtl/core/dxtd_palette.sv
// Color and alpha palette builder for one compressed block.
// Depends on dxtd_pkg (palette_t, expand and divide helpers).
module dxtd_palette
(
    input  logic [15:0]        c0,
    input  logic [15:0]        c1,
    input  logic [7:0]         a0,
    input  logic [7:0]         a1,
    output dxtd_pkg::palette_t pal
);

    logic [2:0][7:0] e0;
    logic [2:0][7:0] e1;
    logic [2:0][7:0] third0;
    logic [2:0][7:0] third1;
    logic [2:0][7:0] half;
    logic [2:0][9:0] n_third0;
    logic [2:0][9:0] n_third1;
    logic [2:0][8:0] n_half;
    logic [7:0][10:0] n7;
    logic [5:0][10:0] n5;
    logic            four;

    assign e0[0] = dxtd_pkg::expand5(c0[15:11]);
    assign e0[1] = dxtd_pkg::expand6(c0[10:5]);
    assign e0[2] = dxtd_pkg::expand5(c0[4:0]);
    assign e1[0] = dxtd_pkg::expand5(c1[15:11]);
    assign e1[1] = dxtd_pkg::expand6(c1[10:5]);
    assign e1[2] = dxtd_pkg::expand5(c1[4:0]);

    assign four = (c0 > c1);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            n_third0[ch] = {1'b0, e0[ch], 1'b0} + {2'b00, e1[ch]};
            n_third1[ch] = {2'b00, e0[ch]} + {1'b0, e1[ch], 1'b0};
            n_half[ch]   = {1'b0, e0[ch]} + {1'b0, e1[ch]};
            third0[ch]   = dxtd_pkg::div3(n_third0[ch]);
            third1[ch]   = dxtd_pkg::div3(n_third1[ch]);
            half[ch]     = n_half[ch][8:1];
        end
    end

    // interpolation sums for the eight- and six-entry alpha ramps
    always_comb
    begin
        n7 = '0;
        n5 = '0;
        for (int i = 1; i < 7; i++)
        begin
            n7[i] = 11'(7 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
        end
        for (int i = 1; i < 5; i++)
        begin
            n5[i] = 11'(5 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
        end
    end

    always_comb
    begin
        pal.four     = four;
        pal.color[0] = e0;
        pal.color[1] = e1;
        if (four)
        begin
            pal.color[2] = third0;
            pal.color[3] = third1;
        end
        else
        begin
            pal.color[2] = half;
            pal.color[3] = '0;
        end

        pal.alpha[0] = a0;
        pal.alpha[1] = a1;
        if (a0 > a1)
        begin
            for (int i = 1; i < 7; i++)
            begin
                pal.alpha[i + 1] = dxtd_pkg::div7(n7[i]);
            end
        end
        else
        begin
            for (int i = 1; i < 5; i++)
            begin
                pal.alpha[i + 1] = dxtd_pkg::div5(n5[i]);
            end
            pal.alpha[6] = 8'h00;
            pal.alpha[7] = 8'hFF;
        end
    end

endmodule

FILE: rtl/core/dxt_texture_block_decoder_unit.sv
// DXT1/DXT3/DXT5 block decoder: one 4x4 block in, four rows of four RGBA texels out.
// Row 0 passes the input reg, palette reg and output reg in turn before it is valid.
// Each block leaves as four row beats read from the palette register, which stall with m_tready;
// a new block is taken into the input register while rows are still going out.
// Reset (rst_n low, async): all stages empty, block_format back to DXT1.
// Depends on dxtd_pkg and dxtd_palette.
module dxt_texture_block_decoder_unit
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data,      // block_format

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,       // [63:0] alpha_word, [127:64] color_word

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,       // [1:0] row_number, [33:2] texel_a, [65:34] texel_b,
                                        // [97:66] texel_c, [129:98] texel_d, rest zero
    output logic         m_tlast        // last_row
);

    logic [1:0]         format_reg;

    logic               a_valid_reg;
    logic [63:0]        a_alpha_reg;
    logic [63:0]        a_color_reg;

    logic               p_valid_reg;
    logic [1:0]         p_row_reg;
    dxtd_pkg::palette_t p_pal_reg;
    logic [3:0][7:0]    p_cidx_reg;
    logic [63:0]        p_alpha_reg;

    logic               o_valid_reg;
    logic [1:0]         o_row_reg;
    logic [3:0][31:0]   o_texel_reg;
    logic               o_last_reg;

    logic               s_accept;
    logic               a_move;
    logic               p_free;
    logic               out_load;
    logic               p_last;

    dxtd_pkg::palette_t pal_w;

    logic [3:0][15:0]   a3_rows;
    logic [3:0][11:0]   a5_rows;
    logic [3:0][1:0]    crow;
    logic [3:0][3:0]    a3row;
    logic [3:0][2:0]    a5row;
    logic [3:0][7:0]    col_alpha;
    logic [3:0][31:0]   row_texel;

    assign cfg_ready = 1'b1;

    assign p_last   = (p_row_reg == dxtd_pkg::LAST_ROW);
    assign out_load = p_valid_reg && (!o_valid_reg || m_tready);
    assign p_free   = !p_valid_reg || (out_load && p_last);
    assign a_move   = a_valid_reg && p_free;
    assign s_tready = !a_valid_reg || p_free;
    assign s_accept = s_tvalid && s_tready;

    dxtd_palette u_palette
    (
        .c0  (a_color_reg[15:0]),
        .c1  (a_color_reg[31:16]),
        .a0  (a_alpha_reg[7:0]),
        .a1  (a_alpha_reg[15:8]),
        .pal (pal_w)
    );

    // row select out of the palette register
    assign a3_rows = p_alpha_reg;
    assign a5_rows = p_alpha_reg[63:16];
    assign crow    = p_cidx_reg[p_row_reg];
    assign a3row   = a3_rows[p_row_reg];
    assign a5row   = a5_rows[p_row_reg];

    always_comb
    begin
        for (int x = 0; x < 4; x++)
        begin
            unique case (format_reg)
                dxtd_pkg::FMT_DXT3:
                begin
                    col_alpha[x] = {a3row[x], a3row[x]};
                end
                dxtd_pkg::FMT_DXT5:
                begin
                    col_alpha[x] = p_pal_reg.alpha[a5row[x]];
                end
                default:
                begin
                    // third-color mode: index 3 is transparent black
                    col_alpha[x] = (crow[x] == 2'd3 && !p_pal_reg.four) ? 8'h00 : 8'hFF;
                end
            endcase
            row_texel[x] = {col_alpha[x], p_pal_reg.color[crow[x]]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg  <= dxtd_pkg::FMT_DXT1;
            a_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            p_row_reg   <= 2'd0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                format_reg <= cfg_data;

            if (s_accept)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;

            if (a_move)
                p_valid_reg <= 1'b1;
            else if (out_load && p_last)
                p_valid_reg <= 1'b0;

            if (a_move)
                p_row_reg <= 2'd0;
            else if (out_load)
                p_row_reg <= p_row_reg + 2'd1;

            if (out_load)
                o_valid_reg <= 1'b1;
            else if (m_tready)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_alpha_reg <= s_tdata[63:0];
            a_color_reg <= s_tdata[127:64];
        end
        if (a_move)
        begin
            p_pal_reg   <= pal_w;
            p_cidx_reg  <= a_color_reg[63:32];
            p_alpha_reg <= a_alpha_reg;
        end
        if (out_load)
        begin
            o_row_reg   <= p_row_reg;
            o_texel_reg <= row_texel;
            o_last_reg  <= p_last;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {6'd0, o_texel_reg, o_row_reg};
    assign m_tlast  = o_last_reg;

endmodule

FILE: rtl/core/dxtd_checker.sv
// Port-level checks for dxt_texture_block_decoder_unit, attached by bind.
// Depends on dxtd_pkg (LAST_ROW).
module dxtd_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tlast
);

    logic [1:0] exp_row_reg;
    logic [2:0] pend_reg;
    logic       in_beat;
    logic       out_beat;
    logic       block_done;

    assign in_beat    = s_tvalid && s_tready;
    assign out_beat   = m_tvalid && m_tready;
    assign block_done = out_beat && m_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= 2'd0;
            pend_reg    <= 3'd0;
        end
        else
        begin
            if (out_beat)
                exp_row_reg <= exp_row_reg + 2'd1;
            if (in_beat && !block_done)
                pend_reg <= pend_reg + 3'd1;
            else if (!in_beat && block_done)
                pend_reg <= pend_reg - 3'd1;
        end
    end

    // tlast marks exactly the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == dxtd_pkg::LAST_ROW)))
        else $error("tlast does not match row number");

    // rows go out 0,1,2,3 per block with no gap or repeat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == exp_row_reg))
        else $error("row out of sequence");

    // no row without a block taken, and at most three blocks held inside
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || pend_reg != 3'd0) && (pend_reg <= 3'd3))
        else $error("block count out of range");

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

endmodule

bind dxt_texture_block_decoder_unit dxtd_checker u_dxtd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: verif/tb_dxt_texture_block_decoder_unit.sv
// Self-checking bench for dxt_texture_block_decoder_unit: DXT1/DXT3/DXT5 and the spare format code.
// A small class predicts the four texel rows of each block and checks them.
// Tasks drive cfg and input; always blocks drive m_tready. Depends on dxtd_pkg and the block RTL.
`timescale 1ns / 100ps

class texel_row_scoreboard;

    typedef struct packed {
        logic [1:0]       row;
        logic [3:0][31:0] texels;
        logic             last;
    } texel_row_t;

    logic [1:0]  block_format;
    texel_row_t  expected_rows[$];
    int unsigned mismatches;
    int unsigned rows_seen;
    int unsigned blocks_per_format[4];

    function new();
        block_format = dxtd_pkg::FMT_DXT1;
        mismatches   = 0;
        rows_seen    = 0;
        foreach (blocks_per_format[i])
            blocks_per_format[i] = 0;
    endfunction

    function void set_format(logic [1:0] fmt);
        block_format = fmt;
    endfunction

    function int unsigned pending();
        return expected_rows.size();
    endfunction

    // 565 -> 888, truncating; [0] red, [1] green, [2] blue
    function logic [2:0][7:0] widen565(logic [15:0] c);
        logic [2:0][7:0] rgb;
        int unsigned     v;
        v      = c[15:11];
        rgb[0] = 8'(v * 255 / 31);
        v      = c[10:5];
        rgb[1] = 8'(v * 255 / 63);
        v      = c[4:0];
        rgb[2] = 8'(v * 255 / 31);
        return rgb;
    endfunction

    // Decode one block into four expected rows.
    function void note_block(logic [63:0] alpha_word, logic [63:0] color_word);
        logic [15:0]     c0;
        logic [15:0]     c1;
        logic [2:0][7:0] e0;
        logic [2:0][7:0] e1;
        logic [2:0][7:0] mix_a;
        logic [2:0][7:0] mix_b;
        logic [31:0]     colors[4];
        int unsigned     alphas[8];
        int unsigned     a0;
        int unsigned     a1;
        int unsigned     t;
        logic [31:0]     texel;
        texel_row_t      row_exp;

        c0 = color_word[15:0];
        c1 = color_word[31:16];
        e0 = widen565(c0);
        e1 = widen565(c1);
        colors[0] = {8'hFF, e0};
        colors[1] = {8'hFF, e1};
        if (c0 > c1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mix_a[k] = 8'((2 * e0[k] + e1[k]) / 3);
                mix_b[k] = 8'((e0[k] + 2 * e1[k]) / 3);
            end
            colors[2] = {8'hFF, mix_a};
            colors[3] = {8'hFF, mix_b};
        end
        else
        begin
            for (int k = 0; k < 3; k++)
                mix_a[k] = 8'((e0[k] + e1[k]) / 2);
            colors[2] = {8'hFF, mix_a};
            colors[3] = 32'h0;           // transparent black
        end

        a0 = alpha_word[7:0];
        a1 = alpha_word[15:8];
        alphas[0] = a0;
        alphas[1] = a1;
        if (a0 > a1)
        begin
            for (int k = 1; k < 7; k++)
                alphas[k + 1] = ((7 - k) * a0 + k * a1) / 7;
        end
        else
        begin
            for (int k = 1; k < 5; k++)
                alphas[k + 1] = ((5 - k) * a0 + k * a1) / 5;
            alphas[6] = 0;
            alphas[7] = 255;
        end

        for (int y = 0; y < 4; y++)
        begin
            row_exp.row = 2'(y);
            for (int x = 0; x < 4; x++)
            begin
                t     = 4 * y + x;
                texel = colors[color_word[32 + 2 * t +: 2]];
                case (block_format)
                    dxtd_pkg::FMT_DXT3: texel[31:24] = 8'(alpha_word[4 * t +: 4] * 17);
                    dxtd_pkg::FMT_DXT5: texel[31:24] = 8'(alphas[alpha_word[16 + 3 * t +: 3]]);
                    default: ;                   // DXT1 and spare code keep palette alpha
                endcase
                row_exp.texels[x] = texel;
            end
            row_exp.last = (row_exp.row == dxtd_pkg::LAST_ROW);
            expected_rows = {expected_rows, row_exp};
        end
        blocks_per_format[block_format]++;
    endfunction

    function void check_row(logic [135:0] data, logic tlast);
        texel_row_t want;
        string      col_names[4] = '{"texel_a", "texel_b", "texel_c", "texel_d"};
        rows_seen++;
        if (expected_rows.size() == 0)
        begin
            $error("row beat with nothing expected: row_number %0d", data[1:0]);
            mismatches++;
            return;
        end
        want = expected_rows.pop_front();
        if (data[1:0] !== want.row)
        begin
            $error("row_number: expected %0d, got %0d", want.row, data[1:0]);
            mismatches++;
        end
        for (int x = 0; x < 4; x++)
        begin
            if (data[2 + 32 * x +: 32] !== want.texels[x])
            begin
                $error("%s: expected %08h, got %08h", col_names[x], want.texels[x],
                       data[2 + 32 * x +: 32]);
                mismatches++;
            end
        end
        if (tlast !== want.last)
        begin
            $error("last_row: expected %0b, got %0b", want.last, tlast);
            mismatches++;
        end
    endfunction

endclass

module tb_dxt_texture_block_decoder_unit;

    localparam logic [1:0] FMT_SPARE        = 2'd3;   // unused code, decodes as DXT1
    localparam int         RANDOM_PHASES    = 10;
    localparam int         BLOCKS_PER_PHASE = 29;
    localparam int         IDLE_LIMIT       = 2000;
    localparam int         DRAIN_CYCLES     = 8;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // [63:0] alpha_word, [127:64] color_word
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;    // [1:0] row_number, [33:2] texel_a .. [129:98] texel_d
    logic         m_tlast;    // last_row

    texel_row_scoreboard rows_sb;

    int unsigned rx_hold     = 0;
    bit          rx_steady   = 1'b0;
    int unsigned idle_cycles = 0;

    dxt_texture_block_decoder_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random stall after each row beat, with calm stretches.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready = 1'b0;
        else if (rx_hold != 0)
        begin
            m_tready = 1'b0;
            rx_hold--;
        end
        else
            m_tready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rows_sb.check_row(m_tdata, m_tlast);
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            rx_hold = rx_steady ? 0 : $urandom_range(0, 16);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_dxt_texture_block_decoder_unit: errors");
                $finish;
            end
        end
    end

    task automatic write_format(logic [1:0] fmt);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = fmt;
        do @(posedge clk); while (!cfg_ready);
        rows_sb.set_format(fmt);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_block(logic [63:0] alpha_word, logic [63:0] color_word, bit steady);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {color_word, alpha_word};
        do @(posedge clk); while (!s_tready);
        rows_sb.note_block(alpha_word, color_word);
    endtask

    // Stop sending and wait for every outstanding row.
    task automatic drain_rows();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (rows_sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [1:0]  fmt_order[4] = '{dxtd_pkg::FMT_DXT1, dxtd_pkg::FMT_DXT3,
                                      dxtd_pkg::FMT_DXT5, FMT_SPARE};
        logic [63:0] dir_alpha[6];
        logic [63:0] dir_color[6];
        logic [63:0] aw;
        logic [63:0] cw;
        logic [1:0]  fmt;
        bit          steady;

        rows_sb   = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = dxtd_pkg::FMT_DXT1;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        // endpoints equal / all ones / max vs min both ways / pure red vs green / 3-color mode
        dir_color = '{64'h0,
                      64'hFFFF_FFFF_FFFF_FFFF,
                      {32'hE4E4_E4E4, 16'h0000, 16'hFFFF},
                      {32'hE4E4_E4E4, 16'hFFFF, 16'h0000},
                      {32'h1B1B_1B1B, 16'h07E0, 16'hF800},
                      {32'hFFAA_5500, 16'hF81F, 16'h001F}};
        // alpha: zero, all ones, a0 > a1 and a0 < a1 with every index, nibble ramp, a0 == a1
        dir_alpha = '{64'h0,
                      64'hFFFF_FFFF_FFFF_FFFF,
                      {48'hFAC688_FAC688, 8'h00, 8'hFF},
                      {48'hFAC688_FAC688, 8'hFF, 8'h00},
                      64'hFEDC_BA98_7654_3210,
                      {48'h4D2E5A_1C7B39, 8'h80, 8'h80}};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first group runs on the reset format
        for (int k = 0; k < 4; k++)
        begin
            if (k != 0)
                write_format(fmt_order[k]);
            for (int n = 0; n < 6; n++)
                send_block(dir_alpha[n], dir_color[n], k[0]);
            drain_rows();
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            fmt = (p < 4) ? 2'(3 - p) : 2'($urandom_range(0, 3));
            write_format(fmt);
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BLOCKS_PER_PHASE; n++)
            begin
                aw = {$urandom, $urandom};
                cw = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0: cw[31:16] = cw[15:0];
                    1: cw[31:0]  = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'hFFFF_0000;
                    2: aw[15:8]  = aw[7:0];
                    3: aw[15:0]  = $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
                    default: ;
                endcase
                send_block(aw, cw, steady);
            end
            drain_rows();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded blocks per format code 0..3: %0d %0d %0d %0d, %0d rows compared",
                 rows_sb.blocks_per_format[0], rows_sb.blocks_per_format[1],
                 rows_sb.blocks_per_format[2], rows_sb.blocks_per_format[3],
                 rows_sb.rows_seen);
        if (rows_sb.pending() != 0)
        begin
            $error("%0d expected rows never arrived", rows_sb.pending());
            rows_sb.mismatches++;
        end
        if (rows_sb.mismatches == 0)
            $display("tb_dxt_texture_block_decoder_unit: clean");
        else
            $display("tb_dxt_texture_block_decoder_unit: errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/dxtd_pkg.sv
rtl/core/dxtd_palette.sv
rtl/core/dxt_texture_block_decoder_unit.sv
rtl/core/dxtd_checker.sv
verif/tb_dxt_texture_block_decoder_unit.sv
